@@ sv/lkkt_pkg.sv @@
package lkkt_pkg;

    // default parameter values
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 24;
    localparam int FRAC_MAX        = 24;

    // field widths
    localparam int VAL_W   = 32;
    localparam int SCALE_W = 31;
    localparam int MULT_W  = 31;
    localparam int LAM_W   = 32;
    localparam int ALPHA_W = 17;
    localparam int RSUM_W  = 64;
    localparam int ROWS_W  = 20;
    localparam int DEN_W   = SCALE_W + ROWS_W;
    localparam int TOTAL_W = 24;
    localparam int CFG_W   = 64;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LAMBDA = 2'd0,
        CFG_ALPHA  = 2'd1,
        CFG_RSUM   = 2'd2,
        CFG_ROWS   = 2'd3
    } t_cfg_idx;

    // controller states
    typedef enum logic [2:0] {
        S_ROW,
        S_DRAIN,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_DIV,
        S_DONE
    } t_state;

    // datapath step per controller state
    typedef enum logic [2:0] {
        ST_NONE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIV_GO
    } t_step;

    typedef struct packed {
        logic  row_take;
        logic  last_take;
        t_step step;
        logic  res_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

@@ sv/lkkt_if.sv @@
interface lkkt_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [lkkt_pkg::VAL_W-1:0] x_value;
    logic signed [lkkt_pkg::VAL_W-1:0] resid;
    logic signed [lkkt_pkg::VAL_W-1:0] col_center;
    logic [lkkt_pkg::SCALE_W-1:0]      col_scale;
    logic [lkkt_pkg::MULT_W-1:0]       penalty_mult;
    logic                              ever_active;
    logic                              in_strong;
    logic                              dome_ok;
    logic                              mode;
    logic                              last_row;
    logic                              last_feature;

    modport source (output valid, x_value, resid, col_center, col_scale, penalty_mult,
                    ever_active, in_strong, dome_ok, mode, last_row, last_feature,
                    input ready);
    modport sink (input valid, x_value, resid, col_center, col_scale, penalty_mult,
                  ever_active, in_strong, dome_ok, mode, last_row, last_feature,
                  output ready);
endinterface

interface lkkt_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lkkt_pkg::VAL_W-1:0] score;
    logic                              examined;
    logic                              new_active;
    logic                              new_strong;
    logic                              violation;
    logic [lkkt_pkg::TOTAL_W-1:0]      violation_total;
    logic                              pass_done;

    modport source (output valid, score, examined, new_active, new_strong, violation,
                    violation_total, pass_done, input ready);
    modport sink (input valid, score, examined, new_active, new_strong, violation,
                  violation_total, pass_done, output ready);
endinterface

@@ sv/lkkt_div.sv @@
module lkkt_div #(
    parameter int FRAC_BITS = lkkt_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [63:0]                i_num,
    input  logic [lkkt_pkg::DEN_W-1:0]        i_den,
    output logic                              o_done,
    output logic signed [lkkt_pkg::VAL_W-1:0] o_z
);
    localparam int DEN_W = lkkt_pkg::DEN_W;
    localparam int DVD_W = 64 + lkkt_pkg::FRAC_MAX;
    localparam int HI_W  = DVD_W - 32;

    logic             r_busy, r_done, r_neg;
    logic [4:0]       r_cnt;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [31:0]      r_lo, r_q, r_z;

    logic             neg;
    logic [63:0]      mag;
    logic [DVD_W-1:0] dvd;
    logic [HI_W-1:0]  hi, den_ext;
    logic [31:0]      lim, r_lim;
    logic [DEN_W:0]   rem2;
    logic             ge;
    logic [31:0]      q_n, q_sat;

    // split the scaled magnitude into the part that decides overflow and the rest
    always_comb begin
        neg     = i_num[63];
        mag     = neg ? (64'd0 - i_num) : i_num;
        dvd     = {{lkkt_pkg::FRAC_MAX{1'b0}}, mag} << FRAC_BITS;
        hi      = dvd[DVD_W-1:32];
        den_ext = {{(HI_W-DEN_W){1'b0}}, i_den};
        lim     = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        r_lim   = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end

    // one quotient bit per cycle
    always_comb begin
        rem2  = {r_rem, r_lo[31]};
        ge    = rem2 >= {1'b0, r_den};
        q_n   = {r_q[30:0], ge};
        q_sat = (q_n > r_lim) ? r_lim : q_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= neg;
                r_den <= i_den;
                r_q   <= 32'd0;
                r_cnt <= 5'd0;
                if (mag == 64'd0) begin
                    r_z    <= 32'd0;
                    r_done <= 1'b1;
                end else if (i_den == '0 || hi >= den_ext) begin
                    // saturated or zero divisor: the limit pattern is chosen by the sign
                    r_z    <= lim;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= hi[DEN_W-1:0];
                    r_lo   <= dvd[31:0];
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? DEN_W'(rem2 - {1'b0, r_den}) : rem2[DEN_W-1:0];
                r_lo  <= {r_lo[30:0], 1'b0};
                r_q   <= q_n;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_z    <= r_neg ? (32'd0 - q_sat) : q_sat;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;

endmodule

@@ sv/lkkt_dp.sv @@
module lkkt_dp #(
    parameter int FRAC_BITS   = lkkt_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = lkkt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_addr,
    input  logic [lkkt_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic signed [lkkt_pkg::VAL_W-1:0]   i_x_value,
    input  logic signed [lkkt_pkg::VAL_W-1:0]   i_resid,
    input  logic signed [lkkt_pkg::VAL_W-1:0]   i_col_center,
    input  logic [lkkt_pkg::SCALE_W-1:0]        i_col_scale,
    input  logic [lkkt_pkg::MULT_W-1:0]         i_penalty_mult,
    input  logic                                i_ever_active,
    input  logic                                i_in_strong,
    input  logic                                i_dome_ok,
    input  logic                                i_mode,
    input  logic                                i_last_feature,
    input  lkkt_pkg::t_cmd                      i_cmd,
    output lkkt_pkg::t_sts                      o_sts,
    output logic signed [lkkt_pkg::VAL_W-1:0]   o_score,
    output logic                                o_examined,
    output logic                                o_new_active,
    output logic                                o_new_strong,
    output logic                                o_violation,
    output logic [lkkt_pkg::TOTAL_W-1:0]        o_violation_total,
    output logic                                o_pass_done
);
    localparam int TOTAL_W = lkkt_pkg::TOTAL_W;

    // configuration
    logic [lkkt_pkg::LAM_W-1:0]   r_lambda;
    logic [lkkt_pkg::ALPHA_W-1:0] r_alpha;
    logic [63:0]                  r_rsum;
    logic [lkkt_pkg::ROWS_W-1:0]  r_rows;

    // sampled on the last row
    logic [31:0]                  r_center;
    logic [lkkt_pkg::SCALE_W-1:0] r_scale;
    logic [lkkt_pkg::MULT_W-1:0]  r_mult;
    logic                         r_act, r_strong, r_dome, r_mode, r_lastf;

    // row pipeline and working registers
    logic                         r_pv, r_psg;
    logic [63:0]                  r_pm, r_acc;
    logic [63:0]                  r_pp0, r_pp1, r_cm, r_num, r_bound;
    logic [62:0]                  r_lmf, r_lm;
    logic [48:0]                  r_ba0;
    logic [47:0]                  r_ba1;
    logic [lkkt_pkg::DEN_W-1:0]   r_den;
    logic [COUNT_WIDTH-1:0]       r_cnt;

    // result registers
    logic [31:0]                  r_score;
    logic                         r_exam_o, r_act_o, r_strong_o, r_viol_o, r_pdone_o;
    logic [TOTAL_W-1:0]           r_total;

    logic signed [63:0] prod;
    logic [63:0]        pmag;
    logic [64:0]        term, acc_sum, cm_s, diff;
    logic [63:0]        acc_sat, num_sat;
    logic               cneg;
    logic [31:0]        c_mag;
    logic [63:0]        rs_mag, cm_lim, cm_val, bnd_val;
    logic [95:0]        cm_full, cm_sh;
    logic [80:0]        ba_full, ba_sh;
    logic               div_start, div_done;
    logic [31:0]        div_z, z_mag;
    logic               exam, viol;
    logic [COUNT_WIDTH-1:0]         cnt_n;
    logic [TOTAL_W+COUNT_WIDTH-1:0] cnt_ext;

    // row product, truncated toward zero
    always_comb begin
        prod = i_x_value * i_resid;
        pmag = prod[63] ? (64'd0 - prod) : prod;
    end

    // saturating accumulate
    always_comb begin
        term    = r_psg ? (65'd0 - {1'b0, r_pm}) : {1'b0, r_pm};
        acc_sum = {r_acc[63], r_acc} + term;
        acc_sat = (acc_sum[64] != acc_sum[63]) ?
                  (acc_sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) :
                  acc_sum[63:0];
    end

    // centre correction and bound
    always_comb begin
        cneg    = r_center[31] ^ r_rsum[63];
        c_mag   = r_center[31] ? (32'd0 - r_center) : r_center;
        rs_mag  = r_rsum[63] ? (64'd0 - r_rsum) : r_rsum;
        cm_full = {r_pp1, 32'd0} + {32'd0, r_pp0};
        cm_sh   = cm_full >> FRAC_BITS;
        cm_lim  = cneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        cm_val  = (|cm_sh[95:64] || cm_sh[63:0] > cm_lim) ? cm_lim : cm_sh[63:0];
        cm_s    = cneg ? (65'd0 - {1'b0, r_cm}) : {1'b0, r_cm};
        diff    = {r_acc[63], r_acc} - cm_s;
        num_sat = (diff[64] != diff[63]) ?
                  (diff[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) :
                  diff[63:0];
        ba_full = {1'b0, r_ba1, 32'd0} + {32'd0, r_ba0};
        ba_sh   = ba_full >> FRAC_BITS;
        bnd_val = (|ba_sh[80:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : ba_sh[63:0];
    end

    // verdict and count
    always_comb begin
        exam    = r_mode ? (r_dome && !r_strong) : (r_strong && !r_act);
        z_mag   = div_z[31] ? (32'd0 - div_z) : div_z;
        viol    = exam && ({32'd0, z_mag} > r_bound);
        cnt_n   = (viol && !(&r_cnt)) ? (r_cnt + {{(COUNT_WIDTH-1){1'b0}}, 1'b1}) : r_cnt;
        cnt_ext = {{TOTAL_W{1'b0}}, cnt_n};
    end

    assign div_start = (i_cmd.step == lkkt_pkg::ST_DIV_GO);

    lkkt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_z     (div_z)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= 32'd65536;
            r_alpha  <= 17'd65536;
            r_rsum   <= 64'd0;
            r_rows   <= 20'd1;
            r_pv     <= 1'b0;
            r_acc    <= 64'd0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (lkkt_pkg::t_cfg_idx'(i_cfg_addr))
                    lkkt_pkg::CFG_LAMBDA: r_lambda <= i_cfg_data[31:0];
                    lkkt_pkg::CFG_ALPHA:  r_alpha  <= i_cfg_data[16:0];
                    lkkt_pkg::CFG_RSUM:   r_rsum   <= i_cfg_data;
                    lkkt_pkg::CFG_ROWS:   r_rows   <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
            r_pv <= i_cmd.row_take;
            if (i_cmd.res_load) begin
                r_acc <= 64'd0;
                r_cnt <= r_lastf ? '0 : cnt_n;
            end else if (r_pv) begin
                r_acc <= acc_sat;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_take) begin
            r_pm  <= pmag >> FRAC_BITS;
            r_psg <= prod[63];
        end
        if (i_cmd.last_take) begin
            r_center <= i_col_center;
            r_scale  <= i_col_scale;
            r_mult   <= i_penalty_mult;
            r_act    <= i_ever_active;
            r_strong <= i_in_strong;
            r_dome   <= i_dome_ok;
            r_mode   <= i_mode;
            r_lastf  <= i_last_feature;
        end
        case (i_cmd.step)
            lkkt_pkg::ST_MUL0: begin
                r_pp0 <= c_mag * rs_mag[31:0];
                r_lmf <= r_lambda * r_mult;
                r_den <= r_scale * r_rows;
            end
            lkkt_pkg::ST_MUL1: begin
                r_pp1 <= c_mag * rs_mag[63:32];
                r_lm  <= r_lmf >> FRAC_BITS;
            end
            lkkt_pkg::ST_MUL2: begin
                r_cm  <= cm_val;
                r_ba0 <= r_lm[31:0] * r_alpha;
            end
            lkkt_pkg::ST_MUL3: begin
                r_num <= num_sat;
                r_ba1 <= r_lm[62:32] * r_alpha;
            end
            lkkt_pkg::ST_DIV_GO: r_bound <= bnd_val;
            default: ;
        endcase
        if (i_cmd.res_load) begin
            r_score    <= exam ? div_z : 32'd0;
            r_exam_o   <= exam;
            r_act_o    <= r_act | viol;
            r_strong_o <= r_strong | (viol & r_mode);
            r_viol_o   <= viol;
            r_total    <= cnt_ext[TOTAL_W-1:0];
            r_pdone_o  <= r_lastf;
        end
    end

    assign o_sts.div_done    = div_done;
    assign o_score           = r_score;
    assign o_examined        = r_exam_o;
    assign o_new_active      = r_act_o;
    assign o_new_strong      = r_strong_o;
    assign o_violation       = r_viol_o;
    assign o_violation_total = r_total;
    assign o_pass_done       = r_pdone_o;

    // the divider is idle whenever a quotient is started
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !u_div.r_busy)
        else $error("divider restarted");

endmodule

@@ sv/lkkt_ctrl.sv @@
module lkkt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last_row,
    input  logic           i_out_ready,
    input  lkkt_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output lkkt_pkg::t_cmd o_cmd
);
    lkkt_pkg::t_state r_state, n_state;
    logic             r_ovalid, n_ovalid;
    logic             take, load;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkkt_pkg::S_ROW:   if (take && i_in_last_row) n_state = lkkt_pkg::S_DRAIN;
            lkkt_pkg::S_DRAIN: n_state = lkkt_pkg::S_P1;
            lkkt_pkg::S_P1:    n_state = lkkt_pkg::S_P2;
            lkkt_pkg::S_P2:    n_state = lkkt_pkg::S_P3;
            lkkt_pkg::S_P3:    n_state = lkkt_pkg::S_P4;
            lkkt_pkg::S_P4:    n_state = lkkt_pkg::S_DIV;
            lkkt_pkg::S_DIV:   if (i_sts.div_done) n_state = lkkt_pkg::S_DONE;
            lkkt_pkg::S_DONE:  if (load) n_state = lkkt_pkg::S_ROW;
            default:           n_state = lkkt_pkg::S_ROW;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = (r_state == lkkt_pkg::S_ROW);
        take       = o_in_ready && i_in_valid;
        load       = (r_state == lkkt_pkg::S_DONE) && (!r_ovalid || i_out_ready);
        o_cmd.row_take  = take;
        o_cmd.last_take = take && i_in_last_row;
        o_cmd.res_load  = load;
        unique case (r_state)
            lkkt_pkg::S_DRAIN: o_cmd.step = lkkt_pkg::ST_MUL0;
            lkkt_pkg::S_P1:    o_cmd.step = lkkt_pkg::ST_MUL1;
            lkkt_pkg::S_P2:    o_cmd.step = lkkt_pkg::ST_MUL2;
            lkkt_pkg::S_P3:    o_cmd.step = lkkt_pkg::ST_MUL3;
            lkkt_pkg::S_P4:    o_cmd.step = lkkt_pkg::ST_DIV_GO;
            default:           o_cmd.step = lkkt_pkg::ST_NONE;
        endcase
        n_ovalid = load ? 1'b1 : (i_out_ready ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lkkt_pkg::S_ROW;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

    // a loaded result is shown and rows are taken again
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_ovalid && r_state == lkkt_pkg::S_ROW))
        else $error("result load lost");

    // a quotient only arrives while waiting for it
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> r_state == lkkt_pkg::S_DIV)
        else $error("divider done out of turn");

    // a waiting result is never overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkkt_pkg::S_DONE && r_ovalid && !i_out_ready)
        |=> r_state == lkkt_pkg::S_DONE)
        else $error("pending result overwritten");

endmodule

@@ sv/lasso_kkt_violation_check.sv @@
// Lasso KKT check for one feature at a time.
// Input channel i_in: one item per row of the feature, (x_value, resid) pairs.
// Rows are taken one per cycle; the item with last_row set also carries the
// feature's centre, scale, penalty multiplier, flags, mode and last_feature.
// Output channel o_out: one item per feature, issued after its last row.
// After the last row, states S_DRAIN and S_P1 to S_P4 form partial products;
// S_P4 starts a restoring divider, which yields a 32-bit quotient one bit per
// cycle and then flags completion, after which the result is loaded. A zero
// numerator, a zero divisor or a saturating quotient skips the division.
// No rows are taken from the last row until the result is loaded. The output
// register holds a result until it is taken; rows of the next feature stream
// in meanwhile, and a second result waits for the first, holding off further
// rows.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_data) are registered;
// the user makes them while the block is idle, which the block does not enforce.
// Synchronous active-low reset loads the register defaults (lambda 1.0,
// alpha 1.0, residual sum 0, rows 1) and clears accumulator and count.
module lasso_kkt_violation_check #(
    parameter int FRAC_BITS   = lkkt_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = lkkt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [lkkt_pkg::CFG_W-1:0] i_cfg_data,
    lkkt_in_if.sink                    i_in,
    lkkt_out_if.source                 o_out
);
    lkkt_pkg::t_cmd cmd;
    lkkt_pkg::t_sts sts;

    lkkt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_last_row (i_in.last_row),
        .i_out_ready   (o_out.ready),
        .i_sts         (sts),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .o_cmd         (cmd)
    );

    lkkt_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_x_value         (i_in.x_value),
        .i_resid           (i_in.resid),
        .i_col_center      (i_in.col_center),
        .i_col_scale       (i_in.col_scale),
        .i_penalty_mult    (i_in.penalty_mult),
        .i_ever_active     (i_in.ever_active),
        .i_in_strong       (i_in.in_strong),
        .i_dome_ok         (i_in.dome_ok),
        .i_mode            (i_in.mode),
        .i_last_feature    (i_in.last_feature),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_score           (o_out.score),
        .o_examined        (o_out.examined),
        .o_new_active      (o_out.new_active),
        .o_new_strong      (o_out.new_strong),
        .o_violation       (o_out.violation),
        .o_violation_total (o_out.violation_total),
        .o_pass_done       (o_out.pass_done)
    );

endmodule
